>>> hw/rtl/cfte_pkg.sv
// ----------------------------------------------------------------------------
// cfte_pkg
// Shared widths, constants, types and the arctangent table of the cube face
// to equirectangular coordinate unit.
// ----------------------------------------------------------------------------
package cfte_pkg;

    localparam int IDX_W            = 12;
    localparam int FACE_SIZE_W      = 13;
    localparam int SRC_SIZE_W       = 15;
    localparam int YAW_W            = 18;
    localparam int OUT_W            = 22;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 18;

    localparam int MAX_FACE_SIZE    = 4096;
    localparam int MAX_SOURCE_SIZE  = 16384;
    localparam int RESULT_FRAC_BITS = 8;
    localparam int CORDIC_STEPS     = 16;
    localparam int TABLE_LEN        = 24;
    localparam int CORDIC_RUN       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    localparam int FSIZE_W          = $clog2(MAX_FACE_SIZE + 1);
    localparam int SM1_W            = $clog2(MAX_SOURCE_SIZE);

    // Q2.16 plane and angle values
    localparam int Q16_FRAC         = 16;
    localparam int Q16_ONE          = 65536;
    localparam int PLANE_W          = 18;
    localparam int T_MAX            = 131071;
    localparam int SIN45_Q16        = 46341;

    // face index divider
    localparam int QUOT_W           = IDX_W + Q16_FRAC + 1;
    localparam int DIV_BPS          = 4;
    localparam int DIV_STAGES       = (QUOT_W + DIV_BPS - 1) / DIV_BPS;
    localparam int DIV_NUM_W        = DIV_STAGES * DIV_BPS;
    localparam int QUOT_SAT         = T_MAX + Q16_ONE;

    // square root
    localparam int SQ_W             = 2 * PLANE_W - 1;
    localparam int RAD_W            = 2 * PLANE_W;
    localparam int ROOT_W           = RAD_W / 2;
    localparam int SQ_REM_W         = ROOT_W + 2;

    // cordic
    localparam int CORD_IN_W        = PLANE_W + 1;
    localparam int CORD_PRE_SHIFT   = 8;
    localparam int CORD_W           = CORD_IN_W + CORD_PRE_SHIFT + 2;
    localparam int Z_W              = 18;

    // wrap and scale
    localparam int WRAP_W           = 21;
    localparam int ANG_W            = 18;
    localparam int PROD_W           = ANG_W + SM1_W;
    localparam int OUT_MAX          = 4194303;

    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] FACE_SIDE   = 2'd0;
    localparam logic [1:0] FACE_BOTTOM = 2'd1;
    localparam logic [1:0] FACE_TOP    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FACE_KIND     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACE_YAW      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACE_WIDTH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACE_HEIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 3'd5;

    typedef struct packed {
        logic [1:0]               face_kind;
        logic signed [YAW_W-1:0]  yaw;
        logic [FSIZE_W-1:0]       face_w;
        logic [FSIZE_W-1:0]       face_h;
        logic [SM1_W-1:0]         src_w_m1;
        logic [SM1_W-1:0]         src_h_m1;
    } cfte_cfg_t;

    typedef struct packed {
        logic signed [PLANE_W-1:0] nx;
        logic signed [PLANE_W-1:0] ny;
    } plane_pair_t;

    // atan(2^-i) in Q16 units of pi
    function automatic logic [Z_W-1:0] arc_angle(input int i);
        logic [Z_W-1:0] r;
        case (i)
            0:       r = 18'd16384;
            1:       r = 18'd9672;
            2:       r = 18'd5110;
            3:       r = 18'd2594;
            4:       r = 18'd1302;
            5:       r = 18'd652;
            6:       r = 18'd326;
            7:       r = 18'd163;
            8:       r = 18'd81;
            9:       r = 18'd41;
            10:      r = 18'd20;
            11:      r = 18'd10;
            12:      r = 18'd5;
            13:      r = 18'd3;
            14:      r = 18'd1;
            15:      r = 18'd1;
            default: r = 18'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/cfte_front.sv
// ----------------------------------------------------------------------------
// cfte_front
// Takes face pixel beats, divides row and column by the face size in a
// pipelined divider and forms the Q2.16 plane values nx and ny.
// ----------------------------------------------------------------------------
module cfte_front
    import cfte_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfte_cfg_t          cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [IDX_W-1:0]   s_col_index,
    input  logic [IDX_W-1:0]   s_row_index,
    output logic               out_valid,
    input  logic               out_ready,
    output plane_pair_t        out_plane
);

    localparam int FL = DIV_STAGES + 4;
    localparam int MUL_W = 2 * PLANE_W;
    localparam logic signed [PLANE_W-1:0] SIN45_S = PLANE_W'(SIN45_Q16);
    localparam logic signed [MUL_W-1:0] ROUND_S = MUL_W'(Q16_ONE / 2);

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [FSIZE_W-1:0]   rem;
        logic [DIV_NUM_W-1:0] quo;
    } div_state_t;

    function automatic div_state_t div_stage(input div_state_t s, input logic [FSIZE_W-1:0] d);
        div_state_t     r;
        logic [FSIZE_W:0] trial;
        r = s;
        for (int k = 0; k < DIV_BPS; k++) begin
            trial = {r.rem, r.num[DIV_NUM_W-1]};
            r.num = {r.num[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, d}) begin
                r.rem = FSIZE_W'(trial - {1'b0, d});
                r.quo = {r.quo[DIV_NUM_W-2:0], 1'b1};
            end else begin
                r.rem = trial[FSIZE_W-1:0];
                r.quo = {r.quo[DIV_NUM_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic signed [PLANE_W-1:0] sat_t(input logic [DIV_NUM_W-1:0] q);
        logic signed [PLANE_W-1:0] r;
        if (q > DIV_NUM_W'(QUOT_SAT)) begin
            r = PLANE_W'(T_MAX);
        end else begin
            r = PLANE_W'(q[PLANE_W-1:0] - PLANE_W'(Q16_ONE));
        end
        return r;
    endfunction

    function automatic logic signed [PLANE_W-1:0] round_plane(input logic signed [MUL_W-1:0] p);
        logic signed [MUL_W-1:0] s;
        s = (p + ROUND_S) >>> Q16_FRAC;
        return s[PLANE_W-1:0];
    endfunction

    div_state_t                 row_div_reg [0:DIV_STAGES];
    div_state_t                 col_div_reg [0:DIV_STAGES];
    logic [FL-1:0]              valid_reg;
    logic signed [PLANE_W-1:0]  row_t_reg, col_t_reg;
    logic signed [MUL_W-1:0]    row_prod_reg, col_prod_reg;
    plane_pair_t                plane_reg;
    logic                       fadv;

    assign fadv      = !valid_reg[FL-1] || out_ready;
    assign s_ready   = fadv;
    assign out_valid = valid_reg[FL-1];
    assign out_plane = plane_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (fadv) begin
            valid_reg <= {valid_reg[FL-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (fadv) begin
            row_div_reg[0].num <= DIV_NUM_W'({s_row_index, {(Q16_FRAC + 1){1'b0}}});
            row_div_reg[0].rem <= '0;
            row_div_reg[0].quo <= '0;
            col_div_reg[0].num <= DIV_NUM_W'({s_col_index, {(Q16_FRAC + 1){1'b0}}});
            col_div_reg[0].rem <= '0;
            col_div_reg[0].quo <= '0;
            for (int i = 0; i < DIV_STAGES; i++) begin
                row_div_reg[i+1] <= div_stage(row_div_reg[i], cfg.face_h);
                col_div_reg[i+1] <= div_stage(col_div_reg[i], cfg.face_w);
            end
            row_t_reg    <= sat_t(row_div_reg[DIV_STAGES].quo);
            col_t_reg    <= sat_t(col_div_reg[DIV_STAGES].quo);
            row_prod_reg <= row_t_reg * SIN45_S;
            col_prod_reg <= col_t_reg * SIN45_S;
            plane_reg.nx <= round_plane(row_prod_reg);
            plane_reg.ny <= round_plane(col_prod_reg);
        end
    end

endmodule

>>> hw/rtl/cfte_queue.sv
// ----------------------------------------------------------------------------
// cfte_queue
// Short queue of plane value pairs between the front and the back.
// ----------------------------------------------------------------------------
module cfte_queue
    import cfte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  plane_pair_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output plane_pair_t out_data
);

    plane_pair_t          mem_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]      count_reg;
    logic                 push, pop;

    assign in_ready  = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_push_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count missed a pop");

endmodule

>>> hw/rtl/cfte_cordic.sv
// ----------------------------------------------------------------------------
// cfte_cordic
// Pipelined vectoring cordic: atan2(y, x) in Q16 units of pi, one
// micro-rotation per stage after a quadrant pre-rotation.
// ----------------------------------------------------------------------------
module cfte_cordic
    import cfte_pkg::*;
(
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [CORD_IN_W-1:0] in_y,
    input  logic signed [CORD_IN_W-1:0] in_x,
    output logic signed [Z_W-1:0]       z_out
);

    localparam logic signed [Z_W-1:0] HALF_Z = Z_W'(Q16_ONE / 2);

    logic signed [CORD_W-1:0] x_reg [0:CORDIC_RUN];
    logic signed [CORD_W-1:0] y_reg [0:CORDIC_RUN];
    logic signed [Z_W-1:0]    z_reg [0:CORDIC_RUN];
    logic                     zero_reg [0:CORDIC_RUN];
    logic signed [CORD_W-1:0] xs, ys;

    assign xs    = CORD_W'(in_x) <<< CORD_PRE_SHIFT;
    assign ys    = CORD_W'(in_y) <<< CORD_PRE_SHIFT;
    assign z_out = zero_reg[CORDIC_RUN] ? '0 : z_reg[CORDIC_RUN];

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            if (xs < 0) begin
                if (ys >= 0) begin
                    x_reg[0] <= ys;
                    y_reg[0] <= -xs;
                    z_reg[0] <= HALF_Z;
                end else begin
                    x_reg[0] <= -ys;
                    y_reg[0] <= xs;
                    z_reg[0] <= -HALF_Z;
                end
            end else begin
                x_reg[0] <= xs;
                y_reg[0] <= ys;
                z_reg[0] <= '0;
            end
            for (int i = 0; i < CORDIC_RUN; i++) begin
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][CORD_W-1]) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + signed'(arc_angle(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - signed'(arc_angle(i));
                end
            end
        end
    end

endmodule

>>> hw/rtl/cfte_back.sv
// ----------------------------------------------------------------------------
// cfte_back
// Squares and square root, two cordic angles, face projection, angle wrap
// and scaling to panorama coordinates, with the output register.
// ----------------------------------------------------------------------------
module cfte_back
    import cfte_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfte_cfg_t          cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  plane_pair_t        in_plane,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [OUT_W-1:0]   m_source_x,
    output logic [OUT_W-1:0]   m_source_y
);

    localparam int BL    = ROOT_W + CORDIC_RUN + 8;
    localparam int MUL_W = 2 * PLANE_W;
    localparam int SUM_W = PROD_W + RESULT_FRAC_BITS + 1;
    localparam logic [SQ_W-1:0] AK_SQ = SQ_W'(64'(SIN45_Q16) * 64'(SIN45_Q16));
    localparam logic signed [CORD_IN_W-1:0] AK_IN = CORD_IN_W'(SIN45_Q16);
    localparam logic signed [WRAP_W-1:0] W_HALF = WRAP_W'(Q16_ONE / 2);
    localparam logic signed [WRAP_W-1:0] W_ONE  = WRAP_W'(Q16_ONE);
    localparam logic signed [WRAP_W-1:0] W_TWO  = WRAP_W'(2 * Q16_ONE);

    function automatic logic [OUT_W-1:0] round_out(input logic [PROD_W-1:0] p);
        logic [SUM_W-1:0] s;
        s = (SUM_W'(p) << RESULT_FRAC_BITS) + SUM_W'(Q16_ONE);
        s = s >> (Q16_FRAC + 1);
        if (s > SUM_W'(OUT_MAX)) begin
            s = SUM_W'(OUT_MAX);
        end
        return s[OUT_W-1:0];
    endfunction

    logic [BL-1:0]              valid_reg;
    logic                       badv;
    logic                       radial;

    logic signed [PLANE_W-1:0]  nx_b0_reg, ny_b0_reg;
    logic [SQ_W-1:0]            sq_a_reg, sq_b_reg;
    logic signed [MUL_W-1:0]    nx_sq, ny_sq;

    logic [RAD_W-1:0]           rad_reg  [0:ROOT_W];
    logic [SQ_REM_W-1:0]        rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]          root_reg [0:ROOT_W];
    logic signed [PLANE_W-1:0]  nx_reg   [0:ROOT_W];
    logic signed [PLANE_W-1:0]  ny_reg   [0:ROOT_W];
    logic [SQ_REM_W-1:0]        rem_next  [1:ROOT_W];
    logic [ROOT_W-1:0]          root_next [1:ROOT_W];

    logic signed [CORD_IN_W-1:0] p_y, p_x, q_y, q_x;
    logic signed [CORD_IN_W-1:0] nx_in, ny_in, root_in;
    logic signed [Z_W-1:0]       z_p, z_q;

    logic signed [WRAP_W-1:0]   u_next, v_next, u_reg, v_reg;
    logic signed [WRAP_W-1:0]   u1_next, v1_next, u1_reg, v1_reg;
    logic signed [WRAP_W-1:0]   u2_next, u2_reg, v2_reg;
    logic [PROD_W-1:0]          px_reg, py_reg;
    logic [OUT_W-1:0]           m_source_x_reg, m_source_y_reg;

    assign badv       = !valid_reg[BL-1] || m_ready;
    assign in_ready   = badv;
    assign m_valid    = valid_reg[BL-1];
    assign m_source_x = m_source_x_reg;
    assign m_source_y = m_source_y_reg;
    assign radial     = (cfg.face_kind == FACE_BOTTOM) || (cfg.face_kind == FACE_TOP);

    assign nx_sq = in_plane.nx * in_plane.nx;
    assign ny_sq = in_plane.ny * in_plane.ny;

    always_comb begin : sqrt_steps
        logic [SQ_REM_W+1:0] rem2;
        logic [SQ_REM_W+1:0] trial;
        for (int i = 0; i < ROOT_W; i++) begin
            rem2  = {rem_reg[i], rad_reg[i][RAD_W-1 -: 2]};
            trial = {2'b00, root_reg[i], 2'b01};
            if (rem2 >= trial) begin
                rem_next[i+1]  = SQ_REM_W'(rem2 - trial);
                root_next[i+1] = {root_reg[i][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[i+1]  = rem2[SQ_REM_W-1:0];
                root_next[i+1] = {root_reg[i][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // cordic operands
    assign nx_in   = CORD_IN_W'(nx_reg[ROOT_W]);
    assign ny_in   = CORD_IN_W'(ny_reg[ROOT_W]);
    assign root_in = signed'({1'b0, root_reg[ROOT_W]});

    always_comb begin
        if (radial) begin
            p_y = (cfg.face_kind == FACE_BOTTOM) ? ny_in : -ny_in;
            p_x = nx_in;
            q_y = root_in;
            q_x = AK_IN;
        end else begin
            p_y = nx_in;
            p_x = AK_IN;
            q_y = ny_in;
            q_x = root_in;
        end
    end

    cfte_cordic u_cordic_p (
        .aclk  (aclk),
        .en    (badv),
        .in_y  (p_y),
        .in_x  (p_x),
        .z_out (z_p)
    );

    cfte_cordic u_cordic_q (
        .aclk  (aclk),
        .en    (badv),
        .in_y  (q_y),
        .in_x  (q_x),
        .z_out (z_q)
    );

    // face projection
    always_comb begin
        unique case (cfg.face_kind)
            FACE_BOTTOM: begin
                u_next = WRAP_W'(z_p);
                v_next = (W_HALF - WRAP_W'(z_q)) <<< 1;
            end
            FACE_TOP: begin
                u_next = WRAP_W'(z_p);
                v_next = (WRAP_W'(z_q) - W_HALF) <<< 1;
            end
            default: begin
                u_next = WRAP_W'(z_p) + WRAP_W'(cfg.yaw);
                v_next = WRAP_W'(z_q) <<< 1;
            end
        endcase
    end

    // wrap v, then u
    always_comb begin
        u1_next = u_reg;
        v1_next = v_reg;
        for (int k = 0; k < 2; k++) begin
            if (v1_next < -W_ONE) begin
                v1_next = v1_next + W_TWO;
                u1_next = u1_next + W_ONE;
            end else if (v1_next > W_ONE) begin
                v1_next = v1_next - W_TWO;
                u1_next = u1_next + W_ONE;
            end
        end
        u2_next = u1_reg;
        for (int k = 0; k < 3; k++) begin
            if (u2_next < -W_ONE) begin
                u2_next = u2_next + W_TWO;
            end else if (u2_next > W_ONE) begin
                u2_next = u2_next - W_TWO;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (badv) begin
            valid_reg <= {valid_reg[BL-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (badv) begin
            nx_b0_reg <= in_plane.nx;
            ny_b0_reg <= in_plane.ny;
            sq_a_reg  <= nx_sq[SQ_W-1:0];
            sq_b_reg  <= radial ? ny_sq[SQ_W-1:0] : AK_SQ;

            rad_reg[0]  <= RAD_W'(sq_a_reg) + RAD_W'(sq_b_reg);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            nx_reg[0]   <= nx_b0_reg;
            ny_reg[0]   <= ny_b0_reg;
            for (int i = 0; i < ROOT_W; i++) begin
                rad_reg[i+1]  <= {rad_reg[i][RAD_W-3:0], 2'b00};
                rem_reg[i+1]  <= rem_next[i+1];
                root_reg[i+1] <= root_next[i+1];
                nx_reg[i+1]   <= nx_reg[i];
                ny_reg[i+1]   <= ny_reg[i];
            end

            u_reg  <= u_next;
            v_reg  <= v_next;
            u1_reg <= u1_next;
            v1_reg <= v1_next;
            u2_reg <= u2_next;
            v2_reg <= v1_reg;
            px_reg <= PROD_W'(unsigned'(ANG_W'(u2_reg + W_ONE))) * PROD_W'(cfg.src_w_m1);
            py_reg <= PROD_W'(unsigned'(ANG_W'(v2_reg + W_ONE))) * PROD_W'(cfg.src_h_m1);
            m_source_x_reg <= round_out(px_reg);
            m_source_y_reg <= round_out(py_reg);
        end
    end

endmodule

>>> hw/rtl/cube_face_to_equirect_coord_unit.sv
// ----------------------------------------------------------------------------
// cube_face_to_equirect_coord_unit
// Maps cube face pixels to equirectangular panorama coordinates.
// ----------------------------------------------------------------------------
// One face pixel beat is taken every clock and one coordinate beat leaves
// every clock while m_ready is high. The front holds the 8-stage radix-16
// index divider, saturation, multiply and rounding; then come the 4-entry
// queue and the back (squares, 18-stage square root, two 17-stage cordic
// units, projection, two wrap stages, scale, output register). Registers
// are to be written by the user only while no beat is in flight; the block
// itself does not enforce this.
module cube_face_to_equirect_coord_unit
    import cfte_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [IDX_W-1:0]        s_col_index,
    input  logic [IDX_W-1:0]        s_row_index,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OUT_W-1:0]        m_source_x,
    output logic [OUT_W-1:0]        m_source_y
);

    function automatic int eff_size(input int v, input int mx);
        int r;
        if (v == 0) begin
            r = 1;
        end else if (v > mx) begin
            r = mx;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [1:0]               face_kind_reg;
    logic signed [YAW_W-1:0]  face_yaw_reg;
    logic [FACE_SIZE_W-1:0]   face_width_reg, face_height_reg;
    logic [SRC_SIZE_W-1:0]    source_width_reg, source_height_reg;
    cfte_cfg_t                cfg;

    logic                     q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    plane_pair_t              q_in_data, q_out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_kind_reg     <= FACE_SIDE;
            face_yaw_reg      <= '0;
            face_width_reg    <= FACE_SIZE_W'(1024);
            face_height_reg   <= FACE_SIZE_W'(1024);
            source_width_reg  <= SRC_SIZE_W'(4096);
            source_height_reg <= SRC_SIZE_W'(2048);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FACE_KIND:     face_kind_reg     <= cfg_data[1:0];
                CFG_FACE_YAW:      face_yaw_reg      <= signed'(cfg_data[YAW_W-1:0]);
                CFG_FACE_WIDTH:    face_width_reg    <= cfg_data[FACE_SIZE_W-1:0];
                CFG_FACE_HEIGHT:   face_height_reg   <= cfg_data[FACE_SIZE_W-1:0];
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[SRC_SIZE_W-1:0];
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data[SRC_SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.face_kind = face_kind_reg;
        cfg.yaw       = face_yaw_reg;
        cfg.face_w    = FSIZE_W'(eff_size(int'(face_width_reg), MAX_FACE_SIZE));
        cfg.face_h    = FSIZE_W'(eff_size(int'(face_height_reg), MAX_FACE_SIZE));
        cfg.src_w_m1  = SM1_W'(eff_size(int'(source_width_reg), MAX_SOURCE_SIZE) - 1);
        cfg.src_h_m1  = SM1_W'(eff_size(int'(source_height_reg), MAX_SOURCE_SIZE) - 1);
    end

    cfte_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_col_index (s_col_index),
        .s_row_index (s_row_index),
        .out_valid   (q_in_valid),
        .out_ready   (q_in_ready),
        .out_plane   (q_in_data)
    );

    cfte_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    cfte_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (q_out_valid),
        .in_ready   (q_out_ready),
        .in_plane   (q_out_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_source_x (m_source_x),
        .m_source_y (m_source_y)
    );

endmodule

>>> bench/cube_face_to_equirect_coord_unit_tb.sv
// ----------------------------------------------------------------------------
// cube_face_to_equirect_coord_unit_tb
// Self-checking bench: a directed table of register writes and face pixels,
// then random phases of configuration and pixel beats with random gaps on
// both sides. Each result beat is compared with a local fixed point model.
// ----------------------------------------------------------------------------
module cube_face_to_equirect_coord_unit_tb;
    import cfte_pkg::*;

    localparam int  CYCLE_LIMIT = 600000;
    localparam int  PHASES      = 12;
    localparam int  PHASE_BEATS = 75;
    localparam bit  ROW_CFG     = 1'b0;
    localparam bit  ROW_PIX     = 1'b1;

    typedef struct {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
    } coord_t;

    typedef struct {
        bit  op;
        int  a;
        int  b;
        bit  chk;
        int  ex;
        int  ey;
    } row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IDX_W-1:0]       s_col_index = '0;
    logic [IDX_W-1:0]       s_row_index = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_W-1:0]       m_source_x;
    logic [OUT_W-1:0]       m_source_y;

    cube_face_to_equirect_coord_unit dut (.*);

    always #10 aclk = ~aclk;

    // model copy of the registers
    logic [1:0]        m_kind;
    logic signed [17:0] m_yaw;
    logic [12:0]       m_fw, m_fh;
    logic [14:0]       m_sw, m_sh;

    coord_t coord_q[$];
    int     fails = 0;
    int     cycles = 0;
    bit     quiet = 1'b0;
    int     arc[24] = '{16384, 9672, 5110, 2594, 1302, 652, 326, 163, 81, 41, 20, 10,
                        5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0};

    function automatic int draw_gap();
        if (quiet || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic longint plane_q16(int idx, int size);
        longint s, t;
        s = (size == 0) ? 1 : ((size > MAX_FACE_SIZE) ? MAX_FACE_SIZE : size);
        t = ((longint'(idx) << 17) / s) - 65536;
        if (t > 131071) t = 131071;
        if (t < -131072) t = -131072;
        return (t * 46341 + 32768) >>> 16;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic int angle_pi(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 32768;
            end else begin
                x = -y; y = t; z = -32768;
            end
        end
        for (int i = 0; i < CORDIC_RUN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arc[i];
            end else begin
                x -= dx; y += dy; z -= arc[i];
            end
        end
        return int'(z);
    endfunction

    function automatic logic [OUT_W-1:0] scale_coord(int a, int size);
        longint s, r;
        s = (size == 0) ? 1 : ((size > MAX_SOURCE_SIZE) ? MAX_SOURCE_SIZE : size);
        r = (((longint'(a) + 65536) * (s - 1) << RESULT_FRAC_BITS) + 65536) >> 17;
        if (r > OUT_MAX) r = OUT_MAX;
        return r[OUT_W-1:0];
    endfunction

    function automatic coord_t map_pixel(int col, int row);
        longint nx, ny, d;
        int u, v, e;
        coord_t c;
        nx = plane_q16(row, m_fh);
        ny = plane_q16(col, m_fw);
        if (m_kind == FACE_BOTTOM || m_kind == FACE_TOP) begin
            d = root_floor(nx * nx + ny * ny);
            e = angle_pi(d, SIN45_Q16);
            if (m_kind == FACE_BOTTOM) begin
                v = 2 * (32768 - e);
                u = angle_pi(ny, nx);
            end else begin
                v = 2 * (e - 32768);
                u = angle_pi(-ny, nx);
            end
        end else begin
            d = root_floor(nx * nx + longint'(SIN45_Q16) * SIN45_Q16);
            u = angle_pi(nx, SIN45_Q16) + int'(m_yaw);
            v = 2 * angle_pi(ny, d);
        end
        while (v < -65536) begin v += 131072; u += 65536; end
        while (v > 65536) begin v -= 131072; u += 65536; end
        while (u < -65536) u += 131072;
        while (u > 65536) u -= 131072;
        c.x = scale_coord(u, m_sw);
        c.y = scale_coord(v, m_sh);
        return c;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int val);
        while (coord_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FACE_KIND:     m_kind = val[1:0];
            CFG_FACE_YAW:      m_yaw  = val[17:0];
            CFG_FACE_WIDTH:    m_fw   = val[12:0];
            CFG_FACE_HEIGHT:   m_fh   = val[12:0];
            CFG_SOURCE_WIDTH:  m_sw   = val[14:0];
            CFG_SOURCE_HEIGHT: m_sh   = val[14:0];
            default: ;
        endcase
    endtask

    // returns once the pixel beat is taken, valid left high
    task automatic send_pixel(int col, int row);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_col_index <= col[IDX_W-1:0];
        s_row_index <= row[IDX_W-1:0];
        do @(posedge aclk); while (!s_ready);
        coord_q.push_back(map_pixel(col, row));
    endtask

    task automatic note_fail(string what, coord_t e, logic [OUT_W-1:0] ax, ay);
        fails++;
        if (fails <= 10)
            $display("mismatch %s: expected x=%0d y=%0d, got x=%0d y=%0d",
                     what, e.x, e.y, ax, ay);
    endtask

    // result side: check and random back-pressure
    int stall = 0;
    always @(posedge aclk) begin
        coord_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (coord_q.size() == 0) begin
                e.x = 'x; e.y = 'x;
                note_fail("unexpected beat", e, m_source_x, m_source_y);
            end else begin
                e = coord_q.pop_front();
                if (e.x !== m_source_x || e.y !== m_source_y)
                    note_fail("coordinate", e, m_source_x, m_source_y);
            end
            stall = draw_gap();
        end else if (stall > 0) begin
            stall--;
        end
        m_ready <= aresetn && stall == 0;
    end

    row_t dir_rows[] = '{
        '{ROW_PIX, 512, 512, 0, 0, 0},
        '{ROW_PIX, 0, 0, 0, 0, 0},
        '{ROW_PIX, 1023, 1023, 0, 0, 0},
        '{ROW_PIX, 4095, 4095, 0, 0, 0},
        '{ROW_PIX, 0, 4095, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_YAW, 65536, 0, 0, 0},
        '{ROW_PIX, 0, 512, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_YAW, -131072, 0, 0, 0},
        '{ROW_PIX, 1023, 0, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_YAW, 131071, 0, 0, 0},
        '{ROW_PIX, 512, 512, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_KIND, FACE_BOTTOM, 0, 0, 0},
        '{ROW_PIX, 512, 512, 0, 0, 0},
        '{ROW_PIX, 0, 0, 0, 0, 0},
        '{ROW_PIX, 1023, 1023, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_KIND, FACE_TOP, 0, 0, 0},
        '{ROW_PIX, 512, 512, 0, 0, 0},
        '{ROW_PIX, 0, 1023, 0, 0, 0},
        '{ROW_PIX, 1023, 0, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_KIND, 3, 0, 0, 0},
        '{ROW_PIX, 100, 900, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_WIDTH, 0, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_HEIGHT, 8191, 0, 0, 0},
        '{ROW_PIX, 4095, 4095, 0, 0, 0},
        '{ROW_PIX, 0, 4095, 0, 0, 0},
        '{ROW_CFG, CFG_SOURCE_WIDTH, 0, 0, 0, 0},
        '{ROW_CFG, CFG_SOURCE_HEIGHT, 1, 0, 0, 0},
        '{ROW_PIX, 7, 9, 1, 0, 0},
        '{ROW_PIX, 4095, 0, 1, 0, 0},
        '{ROW_CFG, CFG_SOURCE_WIDTH, 32767, 0, 0, 0},
        '{ROW_CFG, CFG_SOURCE_HEIGHT, 16384, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_WIDTH, 1, 0, 0, 0},
        '{ROW_CFG, CFG_FACE_HEIGHT, 4096, 0, 0, 0},
        '{ROW_PIX, 0, 0, 0, 0, 0},
        '{ROW_PIX, 4095, 4095, 0, 0, 0}
    };

    function automatic int pick_face_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 4096;
            3: return $urandom_range(4097, 8191);
            default: return $urandom_range(2, 64);
        endcase
    endfunction

    function automatic int pick_source_size();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 16384;
            3: return 32767;
            default: return $urandom_range(2, 16383);
        endcase
    endfunction

    function automatic int pick_index(int size);
        if (size > 1 && $urandom_range(0, 4) != 0)
            return $urandom_range(0, ((size > 4096) ? 4096 : size) - 1);
        return $urandom_range(0, 4095);
    endfunction

    initial begin
        int yaw;
        m_kind = FACE_SIDE;
        m_yaw  = '0;
        m_fw   = 13'd1024;
        m_fh   = 13'd1024;
        m_sw   = 15'd4096;
        m_sh   = 15'd2048;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                s_valid <= 1'b0;
                write_reg(dir_rows[i].a[CFG_INDEX_W-1:0], dir_rows[i].b);
            end else begin
                send_pixel(dir_rows[i].a, dir_rows[i].b);
                if (dir_rows[i].chk) begin
                    coord_q[$].x = dir_rows[i].ex;
                    coord_q[$].y = dir_rows[i].ey;
                end
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            s_valid <= 1'b0;
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: yaw = -131072;
                1: yaw = 131071;
                default: yaw = $urandom_range(0, 262143) - 131072;
            endcase
            write_reg(CFG_FACE_KIND, $urandom_range(0, 3));
            write_reg(CFG_FACE_YAW, yaw);
            write_reg(CFG_FACE_WIDTH, pick_face_size());
            write_reg(CFG_FACE_HEIGHT, pick_face_size());
            write_reg(CFG_SOURCE_WIDTH, pick_source_size());
            write_reg(CFG_SOURCE_HEIGHT, pick_source_size());
            for (int k = 0; k < PHASE_BEATS; k++)
                send_pixel(pick_index(m_fw), pick_index(m_fh));
        end
        s_valid <= 1'b0;

        while (coord_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> cube_face_to_equirect_coord_unit.f
hw/rtl/cfte_pkg.sv
hw/rtl/cfte_front.sv
hw/rtl/cfte_queue.sv
hw/rtl/cfte_cordic.sv
hw/rtl/cfte_back.sv
hw/rtl/cube_face_to_equirect_coord_unit.sv
bench/cube_face_to_equirect_coord_unit_tb.sv
